/* design/ptb_pkg.sv */
// Shared types and constants for the periodic timer bank.
package ptb_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int BANK_MAX   = 16;
  localparam int BANK_CAP   = (NUM_TIMERS < BANK_MAX) ? NUM_TIMERS : BANK_MAX;
  localparam int SLOT_W     = 4;
  localparam int USED_W     = 5;
  localparam int CNT_W      = 32;
  localparam int TAG_W      = 8;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_REG  = 2'd1;
  localparam logic [1:0] OP_ARM  = 2'd2;
  localparam logic [1:0] OP_STOP = 2'd3;

  localparam logic [1:0] KIND_EXPIRY = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [USED_W-1:0] CAP_COUNT = USED_W'(BANK_CAP);

  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  signal_in;
    logic [TAG_W-1:0]  target_in;
    logic [CNT_W-1:0]  timeout_in;
    logic [CNT_W-1:0]  period_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot_out;
    logic [TAG_W-1:0]  signal_out;
    logic [TAG_W-1:0]  target_out;
    logic              last;
  } out_word_t;

  // timer memory: {reload, countdown}; binding memory: {signal, target}
  typedef struct packed {
    logic              rd_en;
    logic              wr_tmr_en;
    logic              wr_bind_en;
    logic [SLOT_W-1:0] addr;
    logic [2*CNT_W-1:0] wr_tmr;
    logic [2*TAG_W-1:0] wr_bind;
  } ptb_mem_req_t;

endpackage

/* design/ptb_store.sv */
// Timer and binding memories, one shared address, registered read data.
module ptb_store (
  input  logic                            clk,
  input  ptb_pkg::ptb_mem_req_t           req,
  output logic [2*ptb_pkg::CNT_W-1:0]     rd_tmr,
  output logic [2*ptb_pkg::TAG_W-1:0]     rd_bind
);
  import ptb_pkg::*;

  logic [2*CNT_W-1:0] tmr_mem  [BANK_MAX];
  logic [2*TAG_W-1:0] bind_mem [BANK_MAX];

  always_ff @(posedge clk) begin
    if (req.wr_tmr_en) begin
      tmr_mem[req.addr] <= req.wr_tmr;
    end
    if (req.wr_bind_en) begin
      bind_mem[req.addr] <= req.wr_bind;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_tmr  <= tmr_mem[req.addr];
      rd_bind <= bind_mem[req.addr];
    end
  end

endmodule

/* design/periodic_timer_bank_top.sv */
// Periodic timer bank: operation sequencer, slot count and result register.
//
//   channel | direction | word        | handshake
//   in      | input     | in_word_t   | in_valid / in_stall
//   out     | output    | out_word_t  | out_valid / out_stall
//
// One operation at a time. Register and arm: write the slot, then load the last word.
// Stop: read, modify, write back. Tick: each registered slot in turn, paced by
// the single memory port (read a slot, then write it back).
// Output stalls hold the sequencer while it has a word to load; the result register
// frees the input side only once the last word is loaded. Reset empties the bank.
module periodic_timer_bank_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ptb_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ptb_pkg::out_word_t out_word
);
  import ptb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_OP   = 5'b00010,
    S_RD   = 5'b00100,
    S_EV   = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  in_word_t          op_r;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [1:0]        fin_kind_r, fin_kind_nxt;
  logic [SLOT_W-1:0] fin_slot_r, fin_slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  ptb_mem_req_t       req;
  logic [2*CNT_W-1:0] rd_tmr;
  logic [2*TAG_W-1:0] rd_bind;

  logic [CNT_W-1:0]  cnt, rel, dec;
  logic              running, expire, out_free, slot_ok, last_slot;

  ptb_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_tmr  (rd_tmr),
    .rd_bind (rd_bind)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign cnt       = rd_tmr[CNT_W-1:0];
  assign rel       = rd_tmr[2*CNT_W-1:CNT_W];
  assign dec       = cnt - CNT_W'(1);
  assign running   = (cnt != '0);
  assign expire    = (cnt == CNT_W'(1));
  assign slot_ok   = ({1'b0, op_r.slot} < used_r);
  assign last_slot = (({1'b0, idx_r} + USED_W'(1)) == used_r);

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    fin_kind_nxt  = fin_kind_r;
    fin_slot_nxt  = fin_slot_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    req           = '0;
    req.addr      = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        state_nxt = S_FIN;
        case (op_r.op)
          OP_TICK: begin
            fin_kind_nxt = KIND_DONE;
            fin_slot_nxt = '0;
            if (used_r != '0) begin
              idx_nxt   = '0;
              state_nxt = S_RD;
            end
          end
          OP_REG: begin
            fin_slot_nxt = '0;
            fin_kind_nxt = KIND_ERROR;
            if (used_r < CAP_COUNT) begin
              req.addr       = used_r[SLOT_W-1:0];
              req.wr_tmr_en  = 1'b1;
              req.wr_bind_en = 1'b1;
              req.wr_tmr     = '0;
              req.wr_bind    = {op_r.signal_in, op_r.target_in};
              used_nxt       = used_r + USED_W'(1);
              fin_kind_nxt   = KIND_DONE;
              fin_slot_nxt   = used_r[SLOT_W-1:0];
            end
          end
          OP_ARM: begin
            fin_slot_nxt = op_r.slot;
            fin_kind_nxt = KIND_ERROR;
            if (slot_ok) begin
              req.addr      = op_r.slot;
              req.wr_tmr_en = 1'b1;
              req.wr_tmr    = {op_r.period_in, op_r.timeout_in};
              fin_kind_nxt  = KIND_DONE;
            end
          end
          default: begin
            fin_slot_nxt = op_r.slot;
            fin_kind_nxt = KIND_ERROR;
            if (slot_ok) begin
              fin_kind_nxt = KIND_DONE;
              idx_nxt      = op_r.slot;
              state_nxt    = S_RD;
            end
          end
        endcase
      end
      S_RD: begin
        req.rd_en = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        if (op_r.op == OP_STOP) begin
          // keep the reload period, clear the countdown
          req.wr_tmr_en = 1'b1;
          req.wr_tmr    = {rel, {CNT_W{1'b0}}};
          state_nxt     = S_FIN;
        end else if (!expire || out_free) begin
          if (expire) begin
            req.wr_tmr_en = 1'b1;
            req.wr_tmr    = {rel, rel};
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{kind: KIND_EXPIRY, slot_out: idx_r,
                              signal_out: rd_bind[2*TAG_W-1:TAG_W],
                              target_out: rd_bind[TAG_W-1:0], last: 1'b0};
          end else if (running) begin
            req.wr_tmr_en = 1'b1;
            req.wr_tmr    = {rel, dec};
          end
          if (last_slot) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r + SLOT_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{kind: fin_kind_r, slot_out: fin_slot_r,
                            signal_out: '0, target_out: '0, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r <= in_word;
    end
    idx_r      <= idx_nxt;
    fin_kind_r <= fin_kind_nxt;
    fin_slot_r <= fin_slot_nxt;
    out_word_r <= out_word_nxt;
  end

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CAP_COUNT)
    else $error("slot count above capacity");

  a_expiry_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind == KIND_EXPIRY |-> !out_word.last)
    else $error("expiry word marked last");

  a_reg_grows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OP && op_r.op == OP_REG && used_r < CAP_COUNT
    |=> used_r == $past(used_r) + USED_W'(1))
    else $error("register did not take a slot");

  a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_OP |=> used_r == $past(used_r))
    else $error("slot count changed outside register");
`endif

endmodule

/* verif/ptb_checker.sv */
`timescale 1ns / 1ps
// Timer bank scoreboard: mirrors the slot state and checks every result word.
module ptb_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ptb_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ptb_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending
);
  import ptb_pkg::*;

  logic [CNT_W-1:0] countdown_m [BANK_MAX];
  logic [CNT_W-1:0] reload_m    [BANK_MAX];
  logic [TAG_W-1:0] signal_m    [BANK_MAX];
  logic [TAG_W-1:0] target_m    [BANK_MAX];
  int unsigned      used_m;
  out_word_t        timer_results_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    used_m     = 0;
  end

  function automatic out_word_t result_word(logic [1:0] kind, logic [SLOT_W-1:0] slot,
                                            logic [TAG_W-1:0] sig, logic [TAG_W-1:0] tgt,
                                            logic last);
    out_word_t w;
    w.kind       = kind;
    w.slot_out   = slot;
    w.signal_out = sig;
    w.target_out = tgt;
    w.last       = last;
    return w;
  endfunction

  // advance the mirrored bank by one accepted word and queue what it must produce
  task automatic run_timer_op(input in_word_t w);
    int unsigned i;
    case (w.op)
      OP_TICK: begin
        for (i = 0; i < used_m; i++) begin
          if (countdown_m[i] != '0) begin
            countdown_m[i] = countdown_m[i] - 1'b1;
            if (countdown_m[i] == '0) begin
              timer_results_q.push_back(result_word(KIND_EXPIRY, SLOT_W'(i), signal_m[i],
                                                    target_m[i], 1'b0));
              countdown_m[i] = reload_m[i];
            end
          end
        end
        timer_results_q.push_back(result_word(KIND_DONE, '0, '0, '0, 1'b1));
      end
      OP_REG: begin
        if (used_m >= BANK_CAP) begin
          timer_results_q.push_back(result_word(KIND_ERROR, '0, '0, '0, 1'b1));
        end else begin
          signal_m[used_m]    = w.signal_in;
          target_m[used_m]    = w.target_in;
          countdown_m[used_m] = '0;
          reload_m[used_m]    = '0;
          timer_results_q.push_back(result_word(KIND_DONE, SLOT_W'(used_m), '0, '0, 1'b1));
          used_m++;
        end
      end
      OP_ARM: begin
        if (w.slot >= used_m) begin
          timer_results_q.push_back(result_word(KIND_ERROR, w.slot, '0, '0, 1'b1));
        end else begin
          countdown_m[w.slot] = w.timeout_in;
          reload_m[w.slot]    = w.period_in;
          timer_results_q.push_back(result_word(KIND_DONE, w.slot, '0, '0, 1'b1));
        end
      end
      default: begin
        if (w.slot >= used_m) begin
          timer_results_q.push_back(result_word(KIND_ERROR, w.slot, '0, '0, 1'b1));
        end else begin
          countdown_m[w.slot] = '0;
          timer_results_q.push_back(result_word(KIND_DONE, w.slot, '0, '0, 1'b1));
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n) begin
      // results never leave in the cycle their word is taken, so check before predicting
      if (out_valid && !out_stall) begin
        if (timer_results_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got kind %0d slot %0d",
                   $time, out_word.kind, out_word.slot_out);
          $display("%0t:   sig %0d tgt %0d last %0d", $time, out_word.signal_out,
                   out_word.target_out, out_word.last);
          fail_count++;
        end else begin
          exp_w = timer_results_q.pop_front();
          check_field("kind", 8'(exp_w.kind), 8'(out_word.kind));
          check_field("slot_out", 8'(exp_w.slot_out), 8'(out_word.slot_out));
          check_field("signal_out", exp_w.signal_out, out_word.signal_out);
          check_field("target_out", exp_w.target_out, out_word.target_out);
          check_field("last", 8'(exp_w.last), 8'(out_word.last));
        end
      end
      if (in_valid && !in_stall)
        run_timer_op(in_word);
      pending = timer_results_q.size();
    end
  end

endmodule

/* verif/periodic_timer_bank_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the periodic timer bank: clock, reset, stimulus and verdict.
module periodic_timer_bank_top_tb;
  import ptb_pkg::*;

  localparam int RANDOM_PER_PHASE = 110;
  localparam int HOLDOFF_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int DRAIN_CYCLES     = 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  int        fail_count;
  int        pending;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_asked  = 0;
  int holdoff_seen   = 0;
  int quiet_cycles   = 0;

  periodic_timer_bank_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  ptb_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: random stall, plus a long hold-off whenever the stimulus asks for one
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_seen != holdoff_asked) begin
        holdoff_seen = holdoff_asked;
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_word_t timer_op(logic [1:0] op, logic [SLOT_W-1:0] slot,
                                        logic [TAG_W-1:0] sig, logic [TAG_W-1:0] tgt,
                                        logic [CNT_W-1:0] timeout, logic [CNT_W-1:0] period);
    in_word_t w;
    w.op         = op;
    w.slot       = slot;
    w.signal_in  = sig;
    w.target_in  = tgt;
    w.timeout_in = timeout;
    w.period_in  = period;
    return w;
  endfunction

  // mostly ticks and short arms so timers keep expiring; unused fields stay random
  function automatic in_word_t random_timer_op();
    in_word_t    w;
    int unsigned pick;
    w.op         = OP_TICK;
    w.slot       = SLOT_W'($urandom_range(15));
    w.signal_in  = TAG_W'($urandom_range(255));
    w.target_in  = TAG_W'($urandom_range(255));
    w.timeout_in = $urandom();
    w.period_in  = $urandom();
    pick = $urandom_range(99);
    if (pick < 45) begin
      w.op = OP_TICK;
    end else if (pick < 75) begin
      w.op = OP_ARM;
      if ($urandom_range(9) != 0) begin
        w.timeout_in = $urandom_range(8);
        w.period_in  = $urandom_range(6);
      end
    end else if (pick < 88) begin
      w.op = OP_STOP;
    end else begin
      w.op = OP_REG;
    end
    return w;
  endfunction

  // entered and left at a falling edge; valid stays up until the word is taken
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_bank_quiet();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int ph;
    int k;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct  = 20;
    recv_stall_pct = 78;

    // empty bank: tick, then arm/stop on slots nobody registered, then three registers
    send_word(timer_op(OP_TICK, 4'd0, 8'h00, 8'h00, 32'h0, 32'h0));
    send_word(timer_op(OP_ARM, 4'd0, 8'h00, 8'h00, 32'd1, 32'd1));
    send_word(timer_op(OP_STOP, 4'd15, 8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff));
    send_word(timer_op(OP_REG, 4'd15, 8'h00, 8'h00, 32'h0, 32'h0));
    send_word(timer_op(OP_REG, 4'd0, 8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff));
    send_word(timer_op(OP_REG, 4'd9, 8'ha5, 8'h5a, 32'h0, 32'h0));
    // one-shot, zero timeout with a stored period, and a period of one
    send_word(timer_op(OP_ARM, 4'd0, 8'h00, 8'h00, 32'd1, 32'd0));
    send_word(timer_op(OP_ARM, 4'd1, 8'h00, 8'h00, 32'd0, 32'd2));
    send_word(timer_op(OP_ARM, 4'd2, 8'h00, 8'h00, 32'd1, 32'd1));
    send_word(timer_op(OP_TICK, 4'd0, 8'h00, 8'h00, 32'h0, 32'h0));
    send_word(timer_op(OP_TICK, 4'd0, 8'h00, 8'h00, 32'h0, 32'h0));
    send_word(timer_op(OP_ARM, 4'd1, 8'h00, 8'h00, 32'hffff_ffff, 32'hffff_ffff));
    send_word(timer_op(OP_STOP, 4'd2, 8'h00, 8'h00, 32'h0, 32'h0));
    send_word(timer_op(OP_STOP, 4'd0, 8'h00, 8'h00, 32'h0, 32'h0));
    send_word(timer_op(OP_ARM, 4'd3, 8'h00, 8'h00, 32'd1, 32'd1));
    send_word(timer_op(OP_TICK, 4'd0, 8'h00, 8'h00, 32'h0, 32'h0));

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 20 : (ph == 1) ? 78 : 0;
      recv_stall_pct = (ph == 0) ? 78 : (ph == 1) ? 20 : 0;
      if (ph == 0) begin
        // fill the remaining slots, then one more register hits the full bank
        for (k = 0; k < BANK_CAP - 3 + 1; k++)
          send_word(timer_op(OP_REG, 4'($urandom_range(15)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), $urandom(), $urandom()));
      end
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (ph == 2 && k == RANDOM_PER_PHASE / 2)
          holdoff_asked++;
        send_word(random_timer_op());
      end
      wait_bank_quiet();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
